@@ design/rc_telemetry_slot_encoder_defines.svh @@
// assertion macros for the telemetry slot encoder
`ifndef RC_TELEMETRY_SLOT_ENCODER_DEFINES_SVH
`define RC_TELEMETRY_SLOT_ENCODER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define RCTS_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define RCTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/rcts_pkg.sv @@
// shared types and constants for the telemetry slot encoder
`default_nettype none

package rcts_pkg;

    localparam int SLOT_COUNT  = 32;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam int MAX_SLOTS   = 8;
    localparam int IDX_W       = $clog2(MAX_SLOTS);
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] RPM_RECIP  = 32'hAAAA_AAAB;
    localparam logic [18:0] DEG_RECIP  = 19'd274877;
    localparam logic [19:0] DEG_SCALE  = 20'd1000000;

    localparam logic [15:0] RPM_CAP    = 16'hFFFF;
    localparam logic [15:0] FLAG_4000  = 16'h4000;
    localparam logic [15:0] FLAG_8000  = 16'h8000;
    localparam logic [15:0] VOLT1_CAP  = 16'h9FFF;
    localparam logic [15:0] VOLT2_CAP  = 16'h1FFF;
    localparam logic [15:0] CURR_CAP   = 16'h3FFF;
    localparam logic [15:0] SPEED_CAP  = 16'h43E7;
    localparam logic [15:0] GPS_TIME   = 16'hB0F0;
    localparam logic [15:0] VARIO_MULT = 16'd10;

    typedef enum logic [2:0] {
        OP_RPM       = 3'd0,
        OP_TEMP      = 3'd1,
        OP_DUAL_VOLT = 3'd2,
        OP_CURRENT   = 3'd3,
        OP_GPS       = 3'd4,
        OP_VARIO     = 3'd5
    } t_op;

    typedef struct packed {
        logic [IDX_W-1:0]             last_idx;
        logic [SLOT_W-1:0]            base;
        logic [MAX_SLOTS-1:0][15:0]   words;
    } t_entry;

    function automatic logic [SLOT_W-1:0] base_to_slot(input logic [4:0] b);
        logic [6:0] x;
        x = 7'(b);
        for (int i = 0; i < 8; i++) begin
            if (x >= 7'(SLOT_COUNT)) begin
                x = x - 7'(SLOT_COUNT);
            end
        end
        return SLOT_W'(x);
    endfunction

endpackage

`default_nettype wire

@@ design/rc_telemetry_slot_encoder.sv @@
// top level of the telemetry slot encoder
// a reading passes the divide pipeline and the queue, then its slots go one by one into the output register
// throughput: one reading per cycle at the input unless the queue is full, one slot per cycle at the output
// while the receiver is ready; a reading has 1 to 8 slots (gps has 8) in the output register
// a 4-entry queue decouples the 3-stage divide pipeline from the slot sequencer
// reset: synchronous active low, clears valid flags, queue pointers and slot index
`default_nettype none
`include "rc_telemetry_slot_encoder_defines.svh"

module rc_telemetry_slot_encoder import rcts_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [2:0]         i_op,
    input  wire logic [4:0]         i_base_slot,
    input  wire logic [31:0]        i_rpm,
    input  wire logic signed [15:0] i_temperature,
    input  wire logic [15:0]        i_first_word,
    input  wire logic [15:0]        i_second_word,
    input  wire logic [15:0]        i_capacity,
    input  wire logic [15:0]        i_speed,
    input  wire logic signed [15:0] i_altitude,
    input  wire logic signed [15:0] i_vario,
    input  wire logic signed [28:0] i_latitude,
    input  wire logic signed [28:0] i_longitude,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [4:0]              o_slot,
    output logic [7:0]              o_data_high,
    output logic [7:0]              o_data_low,
    output logic                    o_last
);

    logic   w_push;
    logic   w_pop;
    logic   w_full;
    logic   w_empty;
    t_entry w_entry;
    t_entry w_head;

    rcts_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_base_slot   (i_base_slot),
        .i_rpm         (i_rpm),
        .i_temperature (i_temperature),
        .i_first_word  (i_first_word),
        .i_second_word (i_second_word),
        .i_capacity    (i_capacity),
        .i_speed       (i_speed),
        .i_altitude    (i_altitude),
        .i_vario       (i_vario),
        .i_latitude    (i_latitude),
        .i_longitude   (i_longitude),
        .o_push        (w_push),
        .o_entry       (w_entry),
        .i_full        (w_full)
    );

    rcts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty)
    );

    rcts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_slot      (o_slot),
        .o_data_high (o_data_high),
        .o_data_low  (o_data_low),
        .o_last      (o_last)
    );

    `RCTS_ASSERT_HOLDS(a_push_not_full, i_clk, i_rst_n, w_push, !w_full, "queue write while full")
    `RCTS_ASSERT_HOLDS(a_pop_not_empty, i_clk, i_rst_n, w_pop, !w_empty, "queue read while empty")
    `RCTS_ASSERT_NEXT(a_pop_frees_entry, i_clk, i_rst_n, w_full && w_pop && !w_push, !w_full, "queue still full after read")

endmodule

`default_nettype wire

@@ design/rcts_front.sv @@
// front end: accepts readings, divides and builds the slot words
`default_nettype none

module rcts_front import rcts_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [2:0]         i_op,
    input  wire logic [4:0]         i_base_slot,
    input  wire logic [31:0]        i_rpm,
    input  wire logic signed [15:0] i_temperature,
    input  wire logic [15:0]        i_first_word,
    input  wire logic [15:0]        i_second_word,
    input  wire logic [15:0]        i_capacity,
    input  wire logic [15:0]        i_speed,
    input  wire logic signed [15:0] i_altitude,
    input  wire logic signed [15:0] i_vario,
    input  wire logic signed [28:0] i_latitude,
    input  wire logic signed [28:0] i_longitude,
    output logic                    o_push,
    output t_entry                  o_entry,
    input  wire logic               i_full
);

    typedef struct packed {
        t_op               op;
        logic [SLOT_W-1:0] base;
        logic [15:0]       temp, w1, w2, cap, spd, alt, vario;
        logic              lat_neg, lon_neg;
    } t_common;

    logic        w_adv;
    logic        w_known;
    logic [28:0] w_lat_raw, w_lon_raw, w_lat_m, w_lon_m;
    t_common     w_c0;

    logic        r1_v, r2_v, r3_v;
    t_common     r1_c, r2_c, r3_c;
    logic [31:0] r1_rpm;
    logic [28:0] r1_lat_m, r1_lon_m, r2_lat_m, r2_lon_m;
    logic [63:0] w_rpm_prod, r2_rpm_prod;
    logic [47:0] w_lat_prod, w_lon_prod;
    logic [9:0]  r2_lat_qp, r2_lon_qp, r3_lat_qp, r3_lon_qp;
    logic [29:0] w_rpm_q;
    logic [29:0] w_lat_qm, w_lon_qm;
    logic [15:0] r3_rpm_sat;
    logic [20:0] r3_lat_r0, r3_lon_r0;

    logic        w_lat_fix, w_lon_fix;
    logic [9:0]  w_lat_deg, w_lon_deg;
    logic [19:0] w_lat_r, w_lon_r;
    logic [15:0] w_v1, w_v2, w_curr, w_spd;
    t_entry      w_entry;

    assign w_adv   = !(r3_v && i_full);
    assign o_ready = w_adv;
    assign o_push  = r3_v && !i_full;
    assign o_entry = w_entry;

    always_comb begin
        unique case (i_op)
            OP_RPM, OP_TEMP, OP_DUAL_VOLT, OP_CURRENT, OP_GPS, OP_VARIO: w_known = 1'b1;
            default: w_known = 1'b0;
        endcase
    end

    assign w_lat_raw = i_latitude;
    assign w_lon_raw = i_longitude;
    assign w_lat_m   = w_lat_raw[28] ? (~w_lat_raw + 29'd1) : w_lat_raw;
    assign w_lon_m   = w_lon_raw[28] ? (~w_lon_raw + 29'd1) : w_lon_raw;

    always_comb begin
        w_c0         = '0;
        w_c0.op      = t_op'(i_op);
        w_c0.base    = base_to_slot(i_base_slot);
        w_c0.temp    = i_temperature;
        w_c0.w1      = i_first_word;
        w_c0.w2      = i_second_word;
        w_c0.cap     = i_capacity;
        w_c0.spd     = i_speed;
        w_c0.alt     = i_altitude;
        w_c0.vario   = i_vario;
        w_c0.lat_neg = w_lat_raw[28];
        w_c0.lon_neg = w_lon_raw[28];
    end

    // valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (w_adv) begin
            r1_v <= i_valid && w_known;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    // reciprocal products
    assign w_rpm_prod = 64'(r1_rpm) * 64'(RPM_RECIP);
    assign w_lat_prod = 48'(r1_lat_m) * 48'(DEG_RECIP);
    assign w_lon_prod = 48'(r1_lon_m) * 48'(DEG_RECIP);

    // quotient estimate back to remainder
    assign w_rpm_q  = r2_rpm_prod[63:34];
    assign w_lat_qm = 30'(r2_lat_qp) * 30'(DEG_SCALE);
    assign w_lon_qm = 30'(r2_lon_qp) * 30'(DEG_SCALE);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_c        <= w_c0;
            r1_rpm      <= i_rpm;
            r1_lat_m    <= w_lat_m;
            r1_lon_m    <= w_lon_m;

            r2_c        <= r1_c;
            r2_rpm_prod <= w_rpm_prod;
            r2_lat_m    <= r1_lat_m;
            r2_lon_m    <= r1_lon_m;
            r2_lat_qp   <= w_lat_prod[47:38];
            r2_lon_qp   <= w_lon_prod[47:38];

            r3_c        <= r2_c;
            r3_rpm_sat  <= (|w_rpm_q[29:16]) ? RPM_CAP : w_rpm_q[15:0];
            r3_lat_qp   <= r2_lat_qp;
            r3_lon_qp   <= r2_lon_qp;
            r3_lat_r0   <= 21'(30'(r2_lat_m) - w_lat_qm);
            r3_lon_r0   <= 21'(30'(r2_lon_m) - w_lon_qm);
        end
    end

    // estimate is low by at most one
    assign w_lat_fix = r3_lat_r0 >= 21'(DEG_SCALE);
    assign w_lon_fix = r3_lon_r0 >= 21'(DEG_SCALE);
    assign w_lat_deg = w_lat_fix ? (r3_lat_qp + 10'd1) : r3_lat_qp;
    assign w_lon_deg = w_lon_fix ? (r3_lon_qp + 10'd1) : r3_lon_qp;
    assign w_lat_r   = w_lat_fix ? 20'(r3_lat_r0 - 21'(DEG_SCALE)) : 20'(r3_lat_r0);
    assign w_lon_r   = w_lon_fix ? 20'(r3_lon_r0 - 21'(DEG_SCALE)) : 20'(r3_lon_r0);

    assign w_v1   = ((r3_c.w1 | FLAG_8000) > VOLT1_CAP) ? VOLT1_CAP : (r3_c.w1 | FLAG_8000);
    assign w_v2   = (r3_c.w2 > VOLT2_CAP) ? VOLT2_CAP : r3_c.w2;
    assign w_curr = (r3_c.w1 > CURR_CAP) ? CURR_CAP : r3_c.w1;
    assign w_spd  = ((r3_c.spd | FLAG_4000) > SPEED_CAP) ? SPEED_CAP : (r3_c.spd | FLAG_4000);

    always_comb begin
        w_entry      = '0;
        w_entry.base = r3_c.base;
        unique case (r3_c.op)
            OP_RPM: begin
                w_entry.last_idx = IDX_W'(0);
                w_entry.words[0] = {r3_rpm_sat[7:0], r3_rpm_sat[15:8]};
            end
            OP_TEMP: begin
                w_entry.last_idx = IDX_W'(0);
                w_entry.words[0] = r3_c.temp | FLAG_4000;
            end
            OP_DUAL_VOLT: begin
                w_entry.last_idx = IDX_W'(1);
                w_entry.words[0] = w_v1;
                w_entry.words[1] = w_v2;
            end
            OP_CURRENT: begin
                w_entry.last_idx = IDX_W'(2);
                w_entry.words[0] = {2'b01, w_curr[13:8], w_curr[7:0]};
                w_entry.words[1] = r3_c.w2;
                w_entry.words[2] = r3_c.cap;
            end
            OP_GPS: begin
                w_entry.last_idx = IDX_W'(7);
                w_entry.words[0] = w_spd;
                w_entry.words[1] = r3_c.alt | FLAG_4000;
                w_entry.words[2] = GPS_TIME;
                w_entry.words[3] = r3_c.vario * VARIO_MULT;
                w_entry.words[4] = {w_lat_deg[7:0], 3'b000, r3_c.lat_neg, w_lat_r[19:16]};
                w_entry.words[5] = w_lat_r[15:0];
                w_entry.words[6] = {w_lon_deg[7:0], 3'b000, r3_c.lon_neg, w_lon_r[19:16]};
                w_entry.words[7] = w_lon_r[15:0];
            end
            OP_VARIO: begin
                w_entry.last_idx = IDX_W'(1);
                w_entry.words[0] = r3_c.vario;
                w_entry.words[1] = r3_c.alt | FLAG_4000;
            end
            default: begin
                w_entry.last_idx = IDX_W'(0);
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/rcts_queue.sv @@
// small queue between front end and slot sequencer
`default_nettype none

module rcts_queue import rcts_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    output logic        o_full,
    input  wire logic   i_pop,
    output t_entry      o_head,
    output logic        o_empty
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW:0]   r_wr, r_rd;

    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[QUEUE_AW] != r_rd[QUEUE_AW]) &&
                     (r_wr[QUEUE_AW-1:0] == r_rd[QUEUE_AW-1:0]);
    assign o_head  = r_mem[r_rd[QUEUE_AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr[QUEUE_AW-1:0]] <= i_entry;
        end
    end

endmodule

`default_nettype wire

@@ design/rcts_back.sv @@
// back end: walks one queued reading slot by slot into the output register
`default_nettype none

module rcts_back import rcts_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_entry i_head,
    input  wire logic   i_empty,
    output logic        o_pop,
    output logic        o_valid,
    input  wire logic   i_ready,
    output logic [4:0]  o_slot,
    output logic [7:0]  o_data_high,
    output logic [7:0]  o_data_low,
    output logic        o_last
);

    logic [IDX_W-1:0]  r_idx;
    logic [SLOT_W-1:0] r_slot_nxt;
    logic              r_valid;
    logic [SLOT_W-1:0] r_slot;
    logic [15:0]       r_word;
    logic              r_last;

    logic              w_load;
    logic              w_end;
    logic [SLOT_W-1:0] w_cur;

    assign w_load = !i_empty && (!r_valid || i_ready);
    assign w_end  = (r_idx == i_head.last_idx);
    assign w_cur  = (r_idx == '0) ? i_head.base : r_slot_nxt;
    assign o_pop  = w_load && w_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= w_end ? '0 : (r_idx + 1'b1);
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_slot     <= w_cur;
            r_word     <= i_head.words[r_idx];
            r_last     <= w_end;
            r_slot_nxt <= (w_cur == SLOT_W'(SLOT_COUNT - 1)) ? '0 : (w_cur + 1'b1);
        end
    end

    assign o_valid     = r_valid;
    assign o_slot      = 5'(r_slot);
    assign o_data_high = r_word[15:8];
    assign o_data_low  = r_word[7:0];
    assign o_last      = r_last;

endmodule

`default_nettype wire

@@ tb/tb_rc_telemetry_slot_encoder.sv @@
// testbench for rc_telemetry_slot_encoder: directed and random readings checked slot by slot
module tb_rc_telemetry_slot_encoder;
    import rcts_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int HOLD_CYCLES    = 150;

    // sensor kinds with no encoding
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic [4:0]  base;
        logic [31:0] rpm;
        logic [15:0] temperature;
        logic [15:0] first_word;
        logic [15:0] second_word;
        logic [15:0] capacity;
        logic [15:0] speed;
        logic [15:0] altitude;
        logic [15:0] vario;
        logic [28:0] latitude;
        logic [28:0] longitude;
    } t_reading;

    typedef struct packed {
        logic [4:0] slot;
        logic [7:0] data_high;
        logic [7:0] data_low;
        logic       last;
    } t_slot;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_op;
    logic [4:0]  i_base_slot;
    logic [31:0] i_rpm;
    logic [15:0] i_temperature;
    logic [15:0] i_first_word;
    logic [15:0] i_second_word;
    logic [15:0] i_capacity;
    logic [15:0] i_speed;
    logic [15:0] i_altitude;
    logic [15:0] i_vario;
    logic [28:0] i_latitude;
    logic [28:0] i_longitude;
    logic        o_valid;
    logic        i_ready;
    logic [4:0]  o_slot;
    logic [7:0]  o_data_high;
    logic [7:0]  o_data_low;
    logic        o_last;

    t_slot expected_slots[$];
    int    mismatches;
    int    stall_count;
    bit    idle_en;
    int    hold_len;

    rc_telemetry_slot_encoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_base_slot   (i_base_slot),
        .i_rpm         (i_rpm),
        .i_temperature (i_temperature),
        .i_first_word  (i_first_word),
        .i_second_word (i_second_word),
        .i_capacity    (i_capacity),
        .i_speed       (i_speed),
        .i_altitude    (i_altitude),
        .i_vario       (i_vario),
        .i_latitude    (i_latitude),
        .i_longitude   (i_longitude),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_slot        (o_slot),
        .o_data_high   (o_data_high),
        .o_data_low    (o_data_low),
        .o_last        (o_last)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // magnitude split into degrees and remainder, sign in bit 4 of the second byte
    function automatic logic [31:0] split_coord(input logic [28:0] raw);
        logic        neg;
        logic [31:0] mag;
        logic [31:0] deg;
        logic [31:0] rem;
        neg = raw[28];
        mag = neg ? (32'h2000_0000 - {3'b000, raw}) : {3'b000, raw};
        deg = mag / 32'd1000000;
        rem = mag % 32'd1000000;
        return {deg[7:0], 3'b000, neg, rem[19:16], rem[15:8], rem[7:0]};
    endfunction

    function automatic void encode_reading(input t_reading r);
        logic [15:0] words[8];
        logic [31:0] quot;
        logic [15:0] v;
        logic [31:0] lat_pair;
        logic [31:0] lon_pair;
        t_slot       s;
        int          n;
        n = 0;
        case (r.op)
            OP_RPM: begin
                quot = r.rpm / 32'd6;
                v = (quot > 32'h0000_FFFF) ? 16'hFFFF : quot[15:0];
                words[0] = {v[7:0], v[15:8]};
                n = 1;
            end
            OP_TEMP: begin
                words[0] = r.temperature | 16'h4000;
                n = 1;
            end
            OP_DUAL_VOLT: begin
                v = r.first_word | 16'h8000;
                words[0] = (v > 16'h9FFF) ? 16'h9FFF : v;
                words[1] = (r.second_word > 16'h1FFF) ? 16'h1FFF : r.second_word;
                n = 2;
            end
            OP_CURRENT: begin
                v = (r.first_word > 16'h3FFF) ? 16'h3FFF : r.first_word;
                words[0] = {(v[15:8] | 8'h40) & 8'h7F, v[7:0]};
                words[1] = r.second_word;
                words[2] = r.capacity;
                n = 3;
            end
            OP_GPS: begin
                v = r.speed | 16'h4000;
                words[0] = (v > 16'h43E7) ? 16'h43E7 : v;
                words[1] = r.altitude | 16'h4000;
                words[2] = 16'hB0F0;
                words[3] = r.vario * 16'd10;
                lat_pair = split_coord(r.latitude);
                lon_pair = split_coord(r.longitude);
                words[4] = lat_pair[31:16];
                words[5] = lat_pair[15:0];
                words[6] = lon_pair[31:16];
                words[7] = lon_pair[15:0];
                n = 8;
            end
            OP_VARIO: begin
                words[0] = r.vario;
                words[1] = r.altitude | 16'h4000;
                n = 2;
            end
            default: n = 0;
        endcase
        for (int k = 0; k < n; k++) begin
            s.slot      = r.base + 5'(k);
            s.data_high = words[k][15:8];
            s.data_low  = words[k][7:0];
            s.last      = (k == n - 1);
            expected_slots.push_back(s);
        end
    endfunction

    function automatic logic [28:0] random_coord();
        int v;
        if ($urandom_range(0, 7) == 0) begin
            return 29'($urandom);
        end
        v = int'($urandom_range(0, 361999998)) - 180999999;
        return 29'(v);
    endfunction

    function automatic t_reading random_reading();
        t_reading r;
        if ($urandom_range(0, 15) == 0) begin
            r.op = ($urandom_range(0, 1) == 0) ? OP_SPARE_A : OP_SPARE_B;
        end else begin
            r.op = 3'($urandom_range(int'(OP_RPM), int'(OP_VARIO)));
        end
        r.base        = 5'($urandom);
        r.rpm         = $urandom;
        r.temperature = 16'($urandom);
        r.first_word  = 16'($urandom);
        r.second_word = 16'($urandom);
        r.capacity    = 16'($urandom);
        r.speed       = 16'($urandom);
        r.altitude    = 16'($urandom);
        r.vario       = 16'($urandom);
        r.latitude    = random_coord();
        r.longitude   = random_coord();
        return r;
    endfunction

    function automatic t_reading with_op(input logic [2:0] op, input logic [4:0] base);
        t_reading r;
        r      = random_reading();
        r.op   = op;
        r.base = base;
        return r;
    endfunction

    // called right after reset or right after the previous transaction
    task automatic send_reading(input t_reading r);
        int gap;
        gap = idle_en ? $urandom_range(0, 6) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_op          <= r.op;
        i_base_slot   <= r.base;
        i_rpm         <= r.rpm;
        i_temperature <= r.temperature;
        i_first_word  <= r.first_word;
        i_second_word <= r.second_word;
        i_capacity    <= r.capacity;
        i_speed       <= r.speed;
        i_altitude    <= r.altitude;
        i_vario       <= r.vario;
        i_latitude    <= r.latitude;
        i_longitude   <= r.longitude;
        i_valid       <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        encode_reading(r);
    endtask

    task automatic test_directed();
        t_reading r;
        r = with_op(OP_RPM, 5'd0);        r.rpm = 32'd0;          send_reading(r);
        r = with_op(OP_RPM, 5'd31);       r.rpm = 32'd5;          send_reading(r);
        r = with_op(OP_RPM, 5'd1);        r.rpm = 32'd393210;     send_reading(r);
        r = with_op(OP_RPM, 5'd2);        r.rpm = 32'd393216;     send_reading(r);
        r = with_op(OP_RPM, 5'd3);        r.rpm = 32'hFFFF_FFFF;  send_reading(r);
        r = with_op(OP_TEMP, 5'd4);       r.temperature = 16'h8000; send_reading(r);
        r = with_op(OP_TEMP, 5'd31);      r.temperature = 16'h7FFF; send_reading(r);
        r = with_op(OP_TEMP, 5'd0);       r.temperature = 16'h0000; send_reading(r);
        r = with_op(OP_DUAL_VOLT, 5'd31);
        r.first_word = 16'h0000; r.second_word = 16'h0000;         send_reading(r);
        r = with_op(OP_DUAL_VOLT, 5'd7);
        r.first_word = 16'hFFFF; r.second_word = 16'hFFFF;         send_reading(r);
        r = with_op(OP_DUAL_VOLT, 5'd8);
        r.first_word = 16'h1FFF; r.second_word = 16'h2000;         send_reading(r);
        r = with_op(OP_CURRENT, 5'd30);
        r.first_word = 16'hFFFF; r.second_word = 16'hFFFF; r.capacity = 16'hFFFF;
        send_reading(r);
        r = with_op(OP_CURRENT, 5'd9);
        r.first_word = 16'h0000; r.second_word = 16'h0000; r.capacity = 16'h0000;
        send_reading(r);
        r = with_op(OP_CURRENT, 5'd10);   r.first_word = 16'h3FFF; send_reading(r);
        // coordinate extremes, wrapped degrees, most negative value
        r = with_op(OP_GPS, 5'd31);
        r.speed = 16'hFFFF; r.altitude = 16'h8000; r.vario = 16'h7FFF;
        r.latitude = 29'd180999999; r.longitude = 29'(-180999999);
        send_reading(r);
        r = with_op(OP_GPS, 5'd26);
        r.speed = 16'h0000; r.altitude = 16'h7FFF; r.vario = 16'h8000;
        r.latitude = 29'h1000_0000; r.longitude = 29'h0FFF_FFFF;
        send_reading(r);
        r = with_op(OP_GPS, 5'd0);
        r.speed = 16'h03E8; r.altitude = 16'h0000; r.vario = 16'h0000;
        r.latitude = 29'd0; r.longitude = 29'h1FFF_FFFF;
        send_reading(r);
        r = with_op(OP_GPS, 5'd24);
        r.speed = 16'h03E7; r.vario = 16'hFFFF;
        r.latitude = 29'(-1); r.longitude = 29'd999999;
        send_reading(r);
        r = with_op(OP_VARIO, 5'd31);
        r.vario = 16'h8000; r.altitude = 16'hFFFF;                 send_reading(r);
        r = with_op(OP_VARIO, 5'd11);
        r.vario = 16'h7FFF; r.altitude = 16'h0000;                 send_reading(r);
        r = with_op(OP_SPARE_A, 5'd12);                            send_reading(r);
        r = with_op(OP_SPARE_B, 5'd13);                            send_reading(r);
        r = with_op(OP_RPM, 5'd14);       r.rpm = 32'd6;          send_reading(r);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            send_reading(random_reading());
        end
    endtask

    // receiver stalls while gps readings keep coming, filling the queue
    task automatic test_back_pressure();
        idle_en  = 1'b0;
        hold_len = HOLD_CYCLES;
        for (int i = 0; i < 40; i++) begin
            send_reading(with_op(OP_GPS, 5'($urandom)));
        end
        idle_en = 1'b1;
    endtask

    task automatic test_no_idle();
        idle_en = 1'b0;
        test_random(40);
        idle_en = 1'b1;
    endtask

    task automatic report_mismatch(input string field, input int expv, input int actv);
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, expv, actv);
    endtask

    // receive side
    initial begin
        int n;
        i_ready = 1'b0;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            if (hold_len != 0) begin
                n = hold_len;
                hold_len = 0;
            end else begin
                n = idle_en ? $urandom_range(0, 6) : 0;
            end
            if (n > 0) begin
                i_ready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_slot e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_slots.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected slot, expected none, actual %0h %0h %0h %0b",
                         $time, o_slot, o_data_high, o_data_low, o_last);
            end else begin
                e = expected_slots.pop_front();
                if (o_slot !== e.slot) report_mismatch("slot", int'(e.slot), int'(o_slot));
                if (o_data_high !== e.data_high)
                    report_mismatch("data_high", int'(e.data_high), int'(o_data_high));
                if (o_data_low !== e.data_low)
                    report_mismatch("data_low", int'(e.data_low), int'(o_data_low));
                if (o_last !== e.last) report_mismatch("last", int'(e.last), int'(o_last));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                stall_count <= 0;
            end else if (stall_count >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end else begin
                stall_count <= stall_count + 1;
            end
        end
    end

    initial begin
        mismatches    = 0;
        stall_count   = 0;
        idle_en       = 1'b1;
        hold_len      = 0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_op          = '0;
        i_base_slot   = '0;
        i_rpm         = '0;
        i_temperature = '0;
        i_first_word  = '0;
        i_second_word = '0;
        i_capacity    = '0;
        i_speed       = '0;
        i_altitude    = '0;
        i_vario       = '0;
        i_latitude    = '0;
        i_longitude   = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(230);
        test_back_pressure();
        test_no_idle();

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_slots.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
